// File: hw/rtl/efv_pkg.sv
package efv_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;
    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    localparam logic signed [15:0] RST_CAL_SCALE     = 16'sd4096;
    localparam logic [14:0]        RST_MAX_ABS_SPEED = 15'd2560;
    localparam logic [30:0]        RST_MAX_ABS_DELTA = 31'd1000;
    localparam logic [1:0]         RST_CHECK_MODE    = 2'd1;
    localparam logic [15:0]        RST_STEER_MIN     = 16'd0;
    localparam logic [15:0]        RST_STEER_MAX     = 16'hFFFF;
    localparam logic [23:0]        RST_TICK_FACTOR   = 24'd0;
    localparam logic [14:0]        RST_TOLERANCE     = 15'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_SCALE     = 3'd0,
        REG_MAX_ABS_SPEED = 3'd1,
        REG_MAX_ABS_DELTA = 3'd2,
        REG_CHECK_MODE    = 3'd3,
        REG_STEER_MIN     = 3'd4,
        REG_STEER_MAX     = 3'd5,
        REG_TICK_FACTOR   = 3'd6,
        REG_TOLERANCE     = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        RSN_OK           = 3'd0,
        RSN_SPEED_NF     = 3'd1,
        RSN_ALIVE        = 3'd2,
        RSN_SPEED_RANGE  = 3'd3,
        RSN_DELTA_RANGE  = 3'd4,
        RSN_STEER_RANGE  = 3'd5,
        RSN_INCONSISTENT = 3'd6
    } reason_t;

    typedef struct packed {
        logic signed [15:0] cal_scale;
        logic [14:0]        max_abs_speed;
        logic [30:0]        max_abs_delta;
        logic [1:0]         check_mode;
        logic [15:0]        steer_min;
        logic [15:0]        steer_max;
        logic [23:0]        tick_factor;
        logic [14:0]        tolerance;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] raw_speed;
        logic               speed_not_finite;
        logic [7:0]         alive_count;
        logic signed [31:0] tick_delta;
        logic [15:0]        steer_adc;
        logic               steer_not_finite;
    } item_t;

    typedef struct packed {
        logic               accepted;
        reason_t            reason_code;
        logic signed [15:0] forward_speed;
    } result_t;

    typedef struct packed {
        logic       seen;
        logic [7:0] last;
    } alive_t;

endpackage

// File: hw/rtl/efv_cfg_regs.sv
module efv_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [efv_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [efv_pkg::CFG_DATA_W-1:0] cfg_data,
    output efv_pkg::cfg_t                  cfg
);
    import efv_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_scale     <= RST_CAL_SCALE;
            cfg_reg.max_abs_speed <= RST_MAX_ABS_SPEED;
            cfg_reg.max_abs_delta <= RST_MAX_ABS_DELTA;
            cfg_reg.check_mode    <= RST_CHECK_MODE;
            cfg_reg.steer_min     <= RST_STEER_MIN;
            cfg_reg.steer_max     <= RST_STEER_MAX;
            cfg_reg.tick_factor   <= RST_TICK_FACTOR;
            cfg_reg.tolerance     <= RST_TOLERANCE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_CAL_SCALE:     cfg_reg.cal_scale     <= $signed(cfg_data[15:0]);
                REG_MAX_ABS_SPEED: cfg_reg.max_abs_speed <= cfg_data[14:0];
                REG_MAX_ABS_DELTA: cfg_reg.max_abs_delta <= cfg_data[30:0];
                REG_CHECK_MODE:    cfg_reg.check_mode    <= cfg_data[1:0];
                REG_STEER_MIN:     cfg_reg.steer_min     <= cfg_data[15:0];
                REG_STEER_MAX:     cfg_reg.steer_max     <= cfg_data[15:0];
                REG_TICK_FACTOR:   cfg_reg.tick_factor   <= cfg_data[23:0];
                REG_TOLERANCE:     cfg_reg.tolerance     <= cfg_data[14:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/efv_check.sv
module efv_check (
    input  efv_pkg::cfg_t    cfg,
    input  efv_pkg::item_t   item,
    input  efv_pkg::alive_t  alive,
    output efv_pkg::result_t result
);
    import efv_pkg::*;

    logic signed [31:0] prod_speed;
    logic signed [19:0] cal;
    logic [19:0]        cal_abs;
    logic               speed_bad;
    logic [31:0]        tick_abs;
    logic               delta_bad;
    logic               steer_bad;
    logic               alive_bad;
    logic signed [56:0] tick_speed;
    logic signed [57:0] cal_q16;
    logic signed [57:0] gap;
    logic [57:0]        gap_abs;
    logic               incons;
    reason_t            reason;

    // Q12.20 product, floor to Q8.8
    assign prod_speed = $signed(item.raw_speed) * $signed(cfg.cal_scale);
    assign cal        = prod_speed[31:12];
    assign cal_abs    = cal[19] ? 20'(-cal) : 20'(cal);
    assign speed_bad  = (cal[19:15] != {5{cal[15]}})
                     || (cal_abs > {5'b0, cfg.max_abs_speed});

    assign tick_abs  = item.tick_delta[31] ? 32'(-item.tick_delta) : 32'(item.tick_delta);
    assign delta_bad = tick_abs > {1'b0, cfg.max_abs_delta};

    assign steer_bad = item.steer_not_finite
                    || (item.steer_adc < cfg.steer_min)
                    || (item.steer_adc > cfg.steer_max);

    assign alive_bad = cfg.check_mode[0] && alive.seen && (item.alive_count == alive.last);

    assign tick_speed = $signed(item.tick_delta) * $signed({1'b0, cfg.tick_factor});
    assign cal_q16    = {{34{cal[15]}}, cal[15:0], 8'b0};
    assign gap        = {tick_speed[56], tick_speed} - cal_q16;
    assign gap_abs    = gap[57] ? 58'(-gap) : 58'(gap);
    assign incons     = cfg.check_mode[1] && (gap_abs > {35'b0, cfg.tolerance, 8'b0});

    always_comb
    begin
        priority if (item.speed_not_finite)
            reason = RSN_SPEED_NF;
        else if (alive_bad)
            reason = RSN_ALIVE;
        else if (speed_bad)
            reason = RSN_SPEED_RANGE;
        else if (delta_bad)
            reason = RSN_DELTA_RANGE;
        else if (steer_bad)
            reason = RSN_STEER_RANGE;
        else if (incons)
            reason = RSN_INCONSISTENT;
        else
            reason = RSN_OK;
    end

    assign result.accepted      = (reason == RSN_OK);
    assign result.reason_code   = reason;
    assign result.forward_speed = (reason == RSN_OK) ? cal[15:0] : 16'sd0;

endmodule

// File: hw/rtl/encoder_feedback_validator.sv
// Channel  | Direction | Payload
// s_*      | in        | tdata: raw_speed, alive_count, tick_delta, steer_adc
//          |           | tuser: speed_not_finite, steer_not_finite
// m_*      | out       | tdata: accepted, reason_code, forward_speed
// cfg_*    | in        | write enable, register index, write data
//
// One item per cycle while the output is not stalled; the result is registered.
// The input register feeds both multipliers and the check chain; the result
// register holds the outcome. The alive state updates as an accepted item moves into
// the result register, so the next item sees it in the following cycle.
// Reset clears valid flags, alive state and configuration to default values.
// A stalled result holds; the input register takes a new item while it is empty or can drain.
module encoder_feedback_validator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] raw_speed, [23:16] alive_count, [55:24] tick_delta, [71:56] steer_adc
    input  logic [efv_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] speed_not_finite, [1] steer_not_finite
    input  logic [efv_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] accepted, [3:1] reason_code, [19:4] forward_speed, [23:20] zero
    output logic [efv_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic [efv_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [efv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import efv_pkg::*;

    cfg_t    cfg;
    item_t   in_item;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t chk_result;
    result_t result_reg;
    logic    result_valid_reg;
    alive_t  alive_reg;
    alive_t  alive_next;
    logic    out_free;
    logic    advance;
    logic    take;

    efv_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    efv_check u_check (
        .cfg    (cfg),
        .item   (item_reg),
        .alive  (alive_reg),
        .result (chk_result)
    );

    assign in_item.raw_speed        = $signed(s_tdata[15:0]);
    assign in_item.alive_count      = s_tdata[23:16];
    assign in_item.tick_delta       = $signed(s_tdata[55:24]);
    assign in_item.steer_adc        = s_tdata[71:56];
    assign in_item.speed_not_finite = s_tuser[0];
    assign in_item.steer_not_finite = s_tuser[1];

    assign out_free = !result_valid_reg || m_tready;
    assign advance  = item_valid_reg && out_free;
    assign s_tready = !item_valid_reg || out_free;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        alive_next = alive_reg;
        if (advance && chk_result.accepted)
        begin
            alive_next.seen = 1'b1;
            alive_next.last = item_reg.alive_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            alive_reg        <= '0;
        end
        else
        begin
            if (take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (m_tready)
                result_valid_reg <= 1'b0;
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= in_item;
        if (advance)
            result_reg <= chk_result;
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = {4'b0, result_reg.forward_speed, result_reg.reason_code,
                       result_reg.accepted};

    a_reject_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !result_reg.accepted) |-> (result_reg.forward_speed == 16'sd0))
        else $error("rejected item carries nonzero speed");

    a_accept_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result_reg.accepted == (result_reg.reason_code == RSN_OK)))
        else $error("accept flag disagrees with reason code");

    a_alive_store: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && chk_result.accepted) |=>
            (alive_reg.seen && (alive_reg.last == $past(item_reg.alive_count))))
        else $error("alive counter not stored on accept");

    a_alive_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && chk_result.accepted) |=> $stable(alive_reg))
        else $error("alive state changed without an accepted item");

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !out_free) |=> (item_valid_reg && $stable(item_reg)))
        else $error("input register lost an item under stall");

endmodule

// File: tb/tb_encoder_feedback_validator.sv
`timescale 1ns / 100ps

module tb_encoder_feedback_validator;
    import efv_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cfg_t       settings;
    logic [7:0] last_alive = 8'd0;
    logic       alive_seen = 1'b0;
    logic [7:0] alive_roll = 8'd0;
    logic       steady = 1'b0;
    item_t      in_hand;
    item_t      outbound_records[$];
    result_t    due_verdicts[$];
    int         mismatches = 0;
    int         stall_cycles = 0;

    encoder_feedback_validator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint draw(longint lo, longint hi);
        bit [31:0] r;
        r = $urandom_range(32'(hi - lo));
        return lo + longint'(r);
    endfunction

    // Q8.8 speed times Q4.12 scale, floored back to Q8.8
    function automatic longint scaled_speed(logic signed [15:0] raw,
                                            logic signed [15:0] scale);
        longint p;
        p = longint'(raw) * longint'(scale);
        return p >>> 12;
    endfunction

    function automatic result_t judge_record(item_t it);
        result_t r;
        longint  cal;
        longint  tick;
        longint  gap;
        r.accepted = 1'b0;
        r.reason_code = RSN_OK;
        r.forward_speed = '0;
        cal = 0;
        tick = longint'(it.tick_delta);
        if (it.speed_not_finite)
            r.reason_code = RSN_SPEED_NF;
        else if (settings.check_mode[0] && alive_seen && it.alive_count == last_alive)
            r.reason_code = RSN_ALIVE;
        else
        begin
            cal = scaled_speed(it.raw_speed, settings.cal_scale);
            if (cal < -32768 || cal > 32767 ||
                magnitude(cal) > longint'(settings.max_abs_speed))
                r.reason_code = RSN_SPEED_RANGE;
            else if (magnitude(tick) > longint'(settings.max_abs_delta))
                r.reason_code = RSN_DELTA_RANGE;
            else if (it.steer_not_finite || it.steer_adc < settings.steer_min ||
                     it.steer_adc > settings.steer_max)
                r.reason_code = RSN_STEER_RANGE;
            else if (settings.check_mode[1])
            begin
                gap = magnitude(tick * longint'(settings.tick_factor) - cal * 256);
                if (gap > longint'(settings.tolerance) * 256)
                    r.reason_code = RSN_INCONSISTENT;
            end
        end
        if (r.reason_code == RSN_OK)
        begin
            r.accepted = 1'b1;
            r.forward_speed = cal[15:0];
            last_alive = it.alive_count;
            alive_seen = 1'b1;
        end
        return r;
    endfunction

    // Driver: hold the item until accepted, predict on every handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                due_verdicts.push_back(judge_record(in_hand));
            if (!s_tvalid || s_tready)
            begin
                if (outbound_records.size() != 0 && (steady || $urandom_range(99) >= 29))
                begin
                    in_hand = outbound_records.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {in_hand.steer_adc, in_hand.tick_delta,
                                in_hand.alive_count, in_hand.raw_speed};
                    s_tuser <= {in_hand.steer_not_finite, in_hand.speed_not_finite};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and watchdog
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            m_tready <= steady || ($urandom_range(99) >= 29);
            if (m_tvalid && m_tready)
            begin
                if (due_verdicts.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected item: acc=%0b reason=%0d speed=%0d",
                                 m_tdata[0], m_tdata[3:1], $signed(m_tdata[19:4]));
                    mismatches++;
                end
                else
                begin
                    want = due_verdicts.pop_front();
                    if (m_tdata[0] !== want.accepted || m_tdata[3:1] !== want.reason_code ||
                        m_tdata[19:4] !== want.forward_speed)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display({"mismatch: expected acc=%0b reason=%0d speed=%0d,",
                                      " got acc=%0b reason=%0d speed=%0d"},
                                     want.accepted, want.reason_code,
                                     want.forward_speed, m_tdata[0], m_tdata[3:1],
                                     $signed(m_tdata[19:4]));
                        mismatches++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb_encoder_feedback_validator failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic cfg_t reset_settings();
        cfg_t c;
        c.cal_scale = RST_CAL_SCALE;
        c.max_abs_speed = RST_MAX_ABS_SPEED;
        c.max_abs_delta = RST_MAX_ABS_DELTA;
        c.check_mode = RST_CHECK_MODE;
        c.steer_min = RST_STEER_MIN;
        c.steer_max = RST_STEER_MAX;
        c.tick_factor = RST_TICK_FACTOR;
        c.tolerance = RST_TOLERANCE;
        return c;
    endfunction

    task automatic drain();
        while (outbound_records.size() != 0 || s_tvalid || due_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_CAL_SCALE:     settings.cal_scale = val[15:0];
            REG_MAX_ABS_SPEED: settings.max_abs_speed = val[14:0];
            REG_MAX_ABS_DELTA: settings.max_abs_delta = val[30:0];
            REG_CHECK_MODE:    settings.check_mode = val[1:0];
            REG_STEER_MIN:     settings.steer_min = val[15:0];
            REG_STEER_MAX:     settings.steer_max = val[15:0];
            REG_TICK_FACTOR:   settings.tick_factor = val[23:0];
            REG_TOLERANCE:     settings.tolerance = val[14:0];
            default:           ;
        endcase
    endtask

    task automatic load_settings(cfg_t c);
        drain();
        cfg_write(REG_CAL_SCALE, CFG_DATA_W'(c.cal_scale));
        cfg_write(REG_MAX_ABS_SPEED, CFG_DATA_W'(c.max_abs_speed));
        cfg_write(REG_MAX_ABS_DELTA, CFG_DATA_W'(c.max_abs_delta));
        cfg_write(REG_CHECK_MODE, CFG_DATA_W'(c.check_mode));
        cfg_write(REG_STEER_MIN, CFG_DATA_W'(c.steer_min));
        cfg_write(REG_STEER_MAX, CFG_DATA_W'(c.steer_max));
        cfg_write(REG_TICK_FACTOR, CFG_DATA_W'(c.tick_factor));
        cfg_write(REG_TOLERANCE, CFG_DATA_W'(c.tolerance));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_rec(longint raw, bit snf, int alive, longint tick, int steer, bit stnf);
        item_t it;
        it.raw_speed = raw[15:0];
        it.speed_not_finite = snf;
        it.alive_count = alive[7:0];
        it.tick_delta = tick[31:0];
        it.steer_adc = steer[15:0];
        it.steer_not_finite = stnf;
        outbound_records.push_back(it);
    endtask

    task automatic roll_settings();
        cfg_t c;
        c.cal_scale = 16'($urandom);
        c.max_abs_speed = 15'(draw(1, 32767));
        c.max_abs_delta = ($urandom_range(1) != 0) ? 31'(draw(1, 5000))
                                                   : 31'(draw(1, 2147483647));
        c.check_mode = 2'($urandom_range(3));
        c.steer_min = 16'(draw(0, 40000));
        c.steer_max = 16'(draw(longint'(c.steer_min), 65535));
        c.tick_factor = ($urandom_range(1) != 0) ? 24'($urandom) : 24'(draw(0, 300000));
        c.tolerance = ($urandom_range(1) != 0) ? 15'(draw(1, 512)) : 15'(draw(1, 32767));
        load_settings(c);
    endtask

    // Mostly well-formed records with random content, the rest noise
    task automatic queue_records(int count);
        item_t  it;
        longint c;
        longint t;
        int     pick;
        repeat (count)
        begin
            pick = int'($urandom_range(99));
            it.raw_speed = 16'($urandom);
            it.alive_count = 8'($urandom);
            it.tick_delta = 32'($urandom);
            it.steer_adc = 16'($urandom);
            it.speed_not_finite = 1'($urandom_range(1));
            it.steer_not_finite = 1'($urandom_range(1));
            if (pick >= 12)
            begin
                it.speed_not_finite = 1'b0;
                it.steer_not_finite = 1'b0;
                if (pick >= 17)
                    alive_roll = alive_roll + 8'd1;
                it.alive_count = alive_roll;
                c = draw(-longint'(settings.max_abs_speed), longint'(settings.max_abs_speed));
                if (settings.cal_scale != 0)
                begin
                    c = clamp((c * 4096) / longint'(settings.cal_scale), -32768, 32767);
                    it.raw_speed = c[15:0];
                end
                c = scaled_speed(it.raw_speed, settings.cal_scale);
                if (settings.check_mode[1] && settings.tick_factor != 0)
                    t = (c * 256) / longint'(settings.tick_factor) + draw(-1, 1);
                else
                    t = draw(-longint'(settings.max_abs_delta), longint'(settings.max_abs_delta));
                t = clamp(t, -longint'(settings.max_abs_delta), longint'(settings.max_abs_delta));
                it.tick_delta = t[31:0];
                if (settings.steer_min <= settings.steer_max)
                    it.steer_adc = 16'(draw(longint'(settings.steer_min),
                                            longint'(settings.steer_max)));
            end
            outbound_records.push_back(it);
        end
    endtask

    initial
    begin
        cfg_t c;
        settings = reset_settings();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        push_rec(0, 1, 1, 0, 0, 0);
        push_rec(256, 0, 5, 10, 1000, 0);
        push_rec(256, 0, 5, 10, 1000, 0);
        push_rec(32767, 0, 6, 0, 0, 0);
        push_rec(-32768, 0, 6, 0, 0, 0);
        push_rec(2560, 0, 6, -1000, 65535, 0);
        push_rec(-2560, 0, 7, 1001, 0, 0);
        push_rec(0, 0, 7, -2147483648, 0, 0);
        push_rec(0, 0, 7, 0, 0, 1);

        c = reset_settings();
        c.cal_scale = -16'sd4096;
        c.max_abs_speed = 15'd32767;
        c.max_abs_delta = 31'h7FFF_FFFF;
        c.check_mode = 2'd3;
        c.steer_min = 16'd100;
        c.steer_max = 16'd200;
        c.tick_factor = 24'd65536;
        load_settings(c);
        push_rec(-512, 0, 8, 2, 100, 0);
        push_rec(-512, 0, 9, 3, 200, 0);
        push_rec(-512, 0, 9, 2, 99, 0);
        push_rec(-512, 0, 9, 2, 201, 0);
        push_rec(-32768, 0, 9, 0, 150, 0);
        push_rec(32767, 0, 9, -128, 150, 0);
        push_rec(0, 0, 10, 2147483647, 150, 0);

        // inverted steering window rejects everything
        c = reset_settings();
        c.check_mode = 2'd0;
        c.steer_min = 16'd300;
        c.steer_max = 16'd200;
        load_settings(c);
        push_rec(0, 0, 0, 0, 250, 0);
        push_rec(0, 0, 0, 0, 300, 0);

        c = reset_settings();
        c.check_mode = 2'd0;
        c.max_abs_speed = 15'd0;
        c.max_abs_delta = 31'd0;
        load_settings(c);
        push_rec(0, 0, 1, 0, 7, 0);
        push_rec(16, 0, 1, 0, 7, 0);
        push_rec(0, 0, 1, -1, 7, 0);

        c.cal_scale = -16'sd32768;
        c.max_abs_speed = 15'd32767;
        c.max_abs_delta = 31'h7FFF_FFFF;
        c.check_mode = 2'd3;
        c.steer_min = 16'd0;
        c.steer_max = 16'hFFFF;
        c.tick_factor = 24'hFF_FFFF;
        c.tolerance = 15'd32767;
        load_settings(c);
        queue_records(150);

        c.cal_scale = 16'sd32767;
        c.max_abs_speed = 15'd1;
        c.max_abs_delta = 31'd1;
        c.check_mode = 2'd1;
        c.steer_min = 16'hFFFF;
        c.steer_max = 16'hFFFF;
        c.tick_factor = 24'd0;
        c.tolerance = 15'd1;
        load_settings(c);
        queue_records(150);

        for (int k = 0; k < 10; k++)
        begin
            roll_settings();
            steady = (k == 4);
            queue_records(165);
        end

        drain();
        steady = 1'b0;
        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_verdicts.size() == 0)
            $display("tb_encoder_feedback_validator passed");
        else
            $display("tb_encoder_feedback_validator failed");
        $finish;
    end

endmodule
